// ----- hw/rtl/psalu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psalu_pkg
// Shared types and constants of the packed integer arithmetic unit: opcode
// codes, lane operation kinds, lane widths and the control word that travels
// down the pipeline with each beat.
// ----------------------------------------------------------------------------
package psalu_pkg;

  localparam int unsigned DataW      = 64;
  localparam int unsigned OpW        = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 16;
  localparam int unsigned DwordW     = 32;
  localparam int unsigned ByteLanes  = DataW / ByteW;
  localparam int unsigned WordLanes  = DataW / WordW;
  localparam int unsigned DwordLanes = DataW / DwordW;

  typedef logic [DataW-1:0] data_t;
  typedef logic [WordLanes-1:0][DwordW-1:0] prod_t;

  // Instruction opcodes
  typedef enum logic [OpW-1:0] {
    OP_ADD_B     = 5'd0,
    OP_ADD_W     = 5'd1,
    OP_ADD_D     = 5'd2,
    OP_SUB_B     = 5'd3,
    OP_SUB_W     = 5'd4,
    OP_SUB_D     = 5'd5,
    OP_ADDS_B    = 5'd6,
    OP_ADDS_W    = 5'd7,
    OP_ADDUS_B   = 5'd8,
    OP_ADDUS_W   = 5'd9,
    OP_SUBS_B    = 5'd10,
    OP_SUBS_W    = 5'd11,
    OP_SUBUS_B   = 5'd12,
    OP_SUBUS_W   = 5'd13,
    OP_MUL_LO    = 5'd14,
    OP_MUL_HI    = 5'd15,
    OP_MADD      = 5'd16
  } op_e;

  // Highest defined opcode; anything above it passes the destination through
  localparam op_e OP_LAST_DEF = OP_MADD;

  // Per-lane operation kinds
  typedef enum logic [3:0] {
    KIND_WRAP_ADD,
    KIND_WRAP_SUB,
    KIND_SSAT_ADD,
    KIND_SSAT_SUB,
    KIND_USAT_ADD,
    KIND_USAT_SUB,
    KIND_MUL_LO,
    KIND_MUL_HI,
    KIND_MADD,
    KIND_PASS
  } kind_e;

  // Lane widths
  typedef enum logic [1:0] {
    LANE_B,
    LANE_W,
    LANE_D
  } lane_e;

  typedef struct packed {
    kind_e kind;
    lane_e lane;
  } ctrl_t;

endpackage

// ----- hw/rtl/psalu_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psalu_if
// Valid/ready channels of the packed integer arithmetic unit: the operation
// channel (opcode and two operands) and the result channel.
// ----------------------------------------------------------------------------
interface psalu_in_if;
  logic                          valid;
  logic                          ready;
  logic [psalu_pkg::OpW-1:0]     opcode;
  logic [psalu_pkg::DataW-1:0]   dst_operand;
  logic [psalu_pkg::DataW-1:0]   src_operand;

  modport source (output valid, output opcode, output dst_operand, output src_operand,
                  input ready);
  modport sink   (input valid, input opcode, input dst_operand, input src_operand,
                  output ready);
endinterface

interface psalu_out_if;
  logic                          valid;
  logic                          ready;
  logic [psalu_pkg::DataW-1:0]   result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ----- hw/rtl/packed_simd_integer_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_simd_integer_alu
// Packed 64-bit integer unit: wrapping, saturating, multiply and multiply-add
// operations on byte, word and double-word lanes.
// ----------------------------------------------------------------------------
// The unit takes one operation beat per clock unless the result channel
// stalls; its result follows decode, lane arithmetic with the four 16x16
// multipliers, then product packing and the multiply-add sums in the output
// register. Each stage carries a valid bit and takes a beat when it is empty
// or its successor takes one, so ready on the input follows the result
// channel's ready combinationally and bubbles are squeezed out during a stall.
// Undefined opcodes return the destination operand unchanged. No state is
// kept between beats.
// ----------------------------------------------------------------------------
module packed_simd_integer_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  psalu_in_if.sink           in_i,
  psalu_out_if.source        out_o
);

  logic             s1_valid, s1_ready;
  psalu_pkg::ctrl_t s1_ctrl;
  psalu_pkg::data_t s1_dst, s1_src;
  logic             s2_valid, s2_ready;
  psalu_pkg::ctrl_t s2_ctrl;
  psalu_pkg::data_t s2_alu;
  psalu_pkg::prod_t s2_prod;

  // Decode stage
  psalu_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .opcode_i (in_i.opcode),
    .dst_i    (in_i.dst_operand),
    .src_i    (in_i.src_operand),
    .valid_o  (s1_valid),
    .ready_i  (s1_ready),
    .ctrl_o   (s1_ctrl),
    .dst_o    (s1_dst),
    .src_o    (s1_src)
  );

  // Lane arithmetic and multiply stage
  psalu_lane u_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .ready_o  (s1_ready),
    .ctrl_i   (s1_ctrl),
    .dst_i    (s1_dst),
    .src_i    (s1_src),
    .valid_o  (s2_valid),
    .ready_i  (s2_ready),
    .ctrl_o   (s2_ctrl),
    .alu_o    (s2_alu),
    .prod_o   (s2_prod)
  );

  // Result packing and output register
  psalu_combine u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid),
    .ready_o  (s2_ready),
    .ctrl_i   (s2_ctrl),
    .alu_i    (s2_alu),
    .prod_i   (s2_prod),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .result_o (out_o.result)
  );

endmodule

// ----- hw/rtl/psalu_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psalu_decode
// First pipeline stage: turns the opcode into a lane kind and lane width and
// registers it together with both operands.
// ----------------------------------------------------------------------------
module psalu_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [psalu_pkg::OpW-1:0]   opcode_i,
  input  psalu_pkg::data_t            dst_i,
  input  psalu_pkg::data_t            src_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output psalu_pkg::ctrl_t            ctrl_o,
  output psalu_pkg::data_t            dst_o,
  output psalu_pkg::data_t            src_o
);

  logic             valid_q;
  psalu_pkg::ctrl_t ctrl_d, ctrl_q;
  psalu_pkg::data_t dst_q, src_q;

  // Decode the opcode; undefined codes pass the destination through
  always_comb begin
    ctrl_d = '{kind: psalu_pkg::KIND_PASS, lane: psalu_pkg::LANE_D};
    case (psalu_pkg::op_e'(opcode_i))
      psalu_pkg::OP_ADD_B:   ctrl_d = '{psalu_pkg::KIND_WRAP_ADD, psalu_pkg::LANE_B};
      psalu_pkg::OP_ADD_W:   ctrl_d = '{psalu_pkg::KIND_WRAP_ADD, psalu_pkg::LANE_W};
      psalu_pkg::OP_ADD_D:   ctrl_d = '{psalu_pkg::KIND_WRAP_ADD, psalu_pkg::LANE_D};
      psalu_pkg::OP_SUB_B:   ctrl_d = '{psalu_pkg::KIND_WRAP_SUB, psalu_pkg::LANE_B};
      psalu_pkg::OP_SUB_W:   ctrl_d = '{psalu_pkg::KIND_WRAP_SUB, psalu_pkg::LANE_W};
      psalu_pkg::OP_SUB_D:   ctrl_d = '{psalu_pkg::KIND_WRAP_SUB, psalu_pkg::LANE_D};
      psalu_pkg::OP_ADDS_B:  ctrl_d = '{psalu_pkg::KIND_SSAT_ADD, psalu_pkg::LANE_B};
      psalu_pkg::OP_ADDS_W:  ctrl_d = '{psalu_pkg::KIND_SSAT_ADD, psalu_pkg::LANE_W};
      psalu_pkg::OP_ADDUS_B: ctrl_d = '{psalu_pkg::KIND_USAT_ADD, psalu_pkg::LANE_B};
      psalu_pkg::OP_ADDUS_W: ctrl_d = '{psalu_pkg::KIND_USAT_ADD, psalu_pkg::LANE_W};
      psalu_pkg::OP_SUBS_B:  ctrl_d = '{psalu_pkg::KIND_SSAT_SUB, psalu_pkg::LANE_B};
      psalu_pkg::OP_SUBS_W:  ctrl_d = '{psalu_pkg::KIND_SSAT_SUB, psalu_pkg::LANE_W};
      psalu_pkg::OP_SUBUS_B: ctrl_d = '{psalu_pkg::KIND_USAT_SUB, psalu_pkg::LANE_B};
      psalu_pkg::OP_SUBUS_W: ctrl_d = '{psalu_pkg::KIND_USAT_SUB, psalu_pkg::LANE_W};
      psalu_pkg::OP_MUL_LO:  ctrl_d = '{psalu_pkg::KIND_MUL_LO,   psalu_pkg::LANE_W};
      psalu_pkg::OP_MUL_HI:  ctrl_d = '{psalu_pkg::KIND_MUL_HI,   psalu_pkg::LANE_W};
      psalu_pkg::OP_MADD:    ctrl_d = '{psalu_pkg::KIND_MADD,     psalu_pkg::LANE_D};
      default:               ctrl_d = '{psalu_pkg::KIND_PASS,     psalu_pkg::LANE_D};
    endcase
  end

  // Take a new beat whenever the stage is empty or draining
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold payload unless a beat is loaded
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctrl_q <= ctrl_d;
      dst_q  <= dst_i;
      src_q  <= src_i;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign dst_o   = dst_q;
  assign src_o   = src_q;

endmodule

// ----- hw/rtl/psalu_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psalu_lane
// Second pipeline stage: lane-wise wrapping add/subtract on all lane widths,
// saturating on bytes and words, and the four signed 16x16 word products.
// ----------------------------------------------------------------------------
module psalu_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  psalu_pkg::ctrl_t  ctrl_i,
  input  psalu_pkg::data_t  dst_i,
  input  psalu_pkg::data_t  src_i,
  output logic              valid_o,
  input  logic              ready_i,
  output psalu_pkg::ctrl_t  ctrl_o,
  output psalu_pkg::data_t  alu_o,
  output psalu_pkg::prod_t  prod_o
);

  localparam int unsigned BW = psalu_pkg::ByteW;
  localparam int unsigned WW = psalu_pkg::WordW;
  localparam int unsigned DW = psalu_pkg::DwordW;

  logic             valid_q;
  psalu_pkg::ctrl_t ctrl_q;
  psalu_pkg::data_t byte_res, word_res, dword_res;
  psalu_pkg::data_t alu_d, alu_q;
  psalu_pkg::prod_t prod_d, prod_q;

  // Byte lanes
  for (genvar i = 0; i < psalu_pkg::ByteLanes; i++) begin : g_byte
    logic [BW-1:0] a, b;
    logic [BW:0]   uadd, usub, sadd, ssub;
    assign a    = dst_i[i*BW +: BW];
    assign b    = src_i[i*BW +: BW];
    assign uadd = {1'b0, a} + {1'b0, b};
    assign usub = {1'b0, a} - {1'b0, b};
    assign sadd = {a[BW-1], a} + {b[BW-1], b};
    assign ssub = {a[BW-1], a} - {b[BW-1], b};
    always_comb begin
      case (ctrl_i.kind)
        psalu_pkg::KIND_WRAP_SUB: byte_res[i*BW +: BW] = usub[BW-1:0];
        psalu_pkg::KIND_SSAT_ADD:
          byte_res[i*BW +: BW] = (sadd[BW] != sadd[BW-1]) ?
                                 {sadd[BW], {(BW-1){!sadd[BW]}}} : sadd[BW-1:0];
        psalu_pkg::KIND_SSAT_SUB:
          byte_res[i*BW +: BW] = (ssub[BW] != ssub[BW-1]) ?
                                 {ssub[BW], {(BW-1){!ssub[BW]}}} : ssub[BW-1:0];
        psalu_pkg::KIND_USAT_ADD:
          byte_res[i*BW +: BW] = uadd[BW] ? {BW{1'b1}} : uadd[BW-1:0];
        psalu_pkg::KIND_USAT_SUB:
          byte_res[i*BW +: BW] = usub[BW] ? {BW{1'b0}} : usub[BW-1:0];
        default:                  byte_res[i*BW +: BW] = uadd[BW-1:0];
      endcase
    end
  end

  // Word lanes and their signed products
  for (genvar i = 0; i < psalu_pkg::WordLanes; i++) begin : g_word
    logic [WW-1:0] a, b;
    logic [WW:0]   uadd, usub, sadd, ssub;
    assign a    = dst_i[i*WW +: WW];
    assign b    = src_i[i*WW +: WW];
    assign uadd = {1'b0, a} + {1'b0, b};
    assign usub = {1'b0, a} - {1'b0, b};
    assign sadd = {a[WW-1], a} + {b[WW-1], b};
    assign ssub = {a[WW-1], a} - {b[WW-1], b};
    assign prod_d[i] = DW'($signed(a) * $signed(b));
    always_comb begin
      case (ctrl_i.kind)
        psalu_pkg::KIND_WRAP_SUB: word_res[i*WW +: WW] = usub[WW-1:0];
        psalu_pkg::KIND_SSAT_ADD:
          word_res[i*WW +: WW] = (sadd[WW] != sadd[WW-1]) ?
                                 {sadd[WW], {(WW-1){!sadd[WW]}}} : sadd[WW-1:0];
        psalu_pkg::KIND_SSAT_SUB:
          word_res[i*WW +: WW] = (ssub[WW] != ssub[WW-1]) ?
                                 {ssub[WW], {(WW-1){!ssub[WW]}}} : ssub[WW-1:0];
        psalu_pkg::KIND_USAT_ADD:
          word_res[i*WW +: WW] = uadd[WW] ? {WW{1'b1}} : uadd[WW-1:0];
        psalu_pkg::KIND_USAT_SUB:
          word_res[i*WW +: WW] = usub[WW] ? {WW{1'b0}} : usub[WW-1:0];
        default:                  word_res[i*WW +: WW] = uadd[WW-1:0];
      endcase
    end
  end

  // Double-word lanes, wrapping only
  for (genvar i = 0; i < psalu_pkg::DwordLanes; i++) begin : g_dword
    always_comb begin
      if (ctrl_i.kind == psalu_pkg::KIND_WRAP_SUB) begin
        dword_res[i*DW +: DW] = dst_i[i*DW +: DW] - src_i[i*DW +: DW];
      end else begin
        dword_res[i*DW +: DW] = dst_i[i*DW +: DW] + src_i[i*DW +: DW];
      end
    end
  end

  // Pick the lane width; pass the destination for undefined opcodes
  always_comb begin
    if (ctrl_i.kind == psalu_pkg::KIND_PASS) begin
      alu_d = dst_i;
    end else begin
      case (ctrl_i.lane)
        psalu_pkg::LANE_B: alu_d = byte_res;
        psalu_pkg::LANE_W: alu_d = word_res;
        default:           alu_d = dword_res;
      endcase
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Register lane results and products
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctrl_q <= ctrl_i;
      alu_q  <= alu_d;
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign alu_o   = alu_q;
  assign prod_o  = prod_q;

endmodule

// ----- hw/rtl/psalu_combine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psalu_combine
// Third pipeline stage and output register: packs the low or high product
// halves, forms the multiply-add pair sums, or forwards the lane result.
// ----------------------------------------------------------------------------
module psalu_combine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  psalu_pkg::ctrl_t  ctrl_i,
  input  psalu_pkg::data_t  alu_i,
  input  psalu_pkg::prod_t  prod_i,
  output logic              valid_o,
  input  logic              ready_i,
  output psalu_pkg::data_t  result_o
);

  localparam int unsigned WW = psalu_pkg::WordW;
  localparam int unsigned DW = psalu_pkg::DwordW;

  logic             valid_q;
  psalu_pkg::data_t mul_lo, mul_hi, madd;
  psalu_pkg::data_t result_d, result_q;

  // Split the products into packed halves
  for (genvar i = 0; i < psalu_pkg::WordLanes; i++) begin : g_half
    assign mul_lo[i*WW +: WW] = prod_i[i][WW-1:0];
    assign mul_hi[i*WW +: WW] = prod_i[i][DW-1:WW];
  end

  // Sum adjacent products, wrapping at 32 bits
  for (genvar i = 0; i < psalu_pkg::DwordLanes; i++) begin : g_madd
    assign madd[i*DW +: DW] = prod_i[2*i] + prod_i[2*i+1];
  end

  always_comb begin
    case (ctrl_i.kind)
      psalu_pkg::KIND_MUL_LO: result_d = mul_lo;
      psalu_pkg::KIND_MUL_HI: result_d = mul_hi;
      psalu_pkg::KIND_MADD:   result_d = madd;
      default:                result_d = alu_i;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the result while the sink stalls
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- hw/rtl/psalu_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psalu_chk
// Port-level checks of the packed integer unit: result hold under stall,
// latency with a free-running sink, pass-through of undefined opcodes.
// ----------------------------------------------------------------------------
module psalu_chk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [psalu_pkg::OpW-1:0]   in_opcode_i,
  input  psalu_pkg::data_t            in_dst_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  psalu_pkg::data_t            out_result_i
);

  logic in_acc;
  logic undef_op;

  assign in_acc   = in_valid_i && in_ready_i;
  assign undef_op = in_opcode_i > psalu_pkg::OP_LAST_DEF;

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_result_i))
    else $error("result beat changed while stalled");

  // A free sink never blocks the operation channel
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("operation channel blocked with sink ready");

  // With the sink ready, a result shows once the beat has passed the decode, lane and combine stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after three cycles");

  // Undefined opcodes return the destination operand
  a_undef_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && undef_op) ##1 out_ready_i ##1 out_ready_i
      |=> out_result_i == $past(in_dst_i, 3))
    else $error("undefined opcode altered destination");

endmodule

bind packed_simd_integer_alu psalu_chk u_psalu_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .in_dst_i     (in_i.dst_operand),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result)
);

// ----- bench/tb_packed_simd_integer_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_simd_integer_alu
// Self-checking bench for the packed integer unit. Each operation beat
// accepted on the input channel is run through a lane-by-lane arithmetic
// model. The predicted word is queued and compared in order with every beat
// that leaves the result channel. Directed corner operands come first, then
// random beats under three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_packed_simd_integer_alu;

  typedef logic [psalu_pkg::OpW-1:0] opcode_t;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned PhaseBeats = 330;
  localparam opcode_t     OpUndefLo  = 5'd17;
  localparam opcode_t     OpUndefHi  = 5'd31;

  logic clk_i;
  logic rst_ni;

  psalu_in_if  in_ch ();
  psalu_out_if out_ch ();

  packed_simd_integer_alu dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // --------------------------------------------------------------------------
  // Arithmetic model
  // --------------------------------------------------------------------------

  // Sign-extend the low w bits of v
  function automatic longint lane_signed(psalu_pkg::data_t v, int unsigned w);
    longint sbit;
    sbit = longint'(64'd1 << (w - 1));
    return longint'(v ^ psalu_pkg::data_t'(sbit)) - sbit;
  endfunction

  function automatic longint clamp_lane(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One lane of width w; a and b hold only the lane bits
  function automatic psalu_pkg::data_t lane_calc(psalu_pkg::kind_e kind,
                                                 psalu_pkg::data_t a,
                                                 psalu_pkg::data_t b,
                                                 int unsigned w);
    longint m;
    longint smax;
    longint sa;
    longint sb;
    longint ua;
    longint ub;
    longint r;
    m    = longint'((64'd1 << w) - 64'd1);
    smax = m >>> 1;
    sa   = lane_signed(a, w);
    sb   = lane_signed(b, w);
    ua   = longint'(a);
    ub   = longint'(b);
    case (kind)
      psalu_pkg::KIND_WRAP_ADD: r = ua + ub;
      psalu_pkg::KIND_WRAP_SUB: r = ua - ub;
      psalu_pkg::KIND_SSAT_ADD: r = clamp_lane(sa + sb, -smax - 1, smax);
      psalu_pkg::KIND_SSAT_SUB: r = clamp_lane(sa - sb, -smax - 1, smax);
      psalu_pkg::KIND_USAT_ADD: r = clamp_lane(ua + ub, 0, m);
      psalu_pkg::KIND_USAT_SUB: r = clamp_lane(ua - ub, 0, m);
      psalu_pkg::KIND_MUL_LO:   r = sa * sb;
      default:                  r = (sa * sb) >>> 16;
    endcase
    return psalu_pkg::data_t'(r & m);
  endfunction

  // Apply one lane operation across all lanes of width w
  function automatic psalu_pkg::data_t lanewise(psalu_pkg::kind_e kind,
                                                psalu_pkg::data_t d,
                                                psalu_pkg::data_t s,
                                                int unsigned w);
    psalu_pkg::data_t m;
    psalu_pkg::data_t acc;
    int unsigned      pos;
    m   = (64'd1 << w) - 64'd1;
    acc = '0;
    for (pos = 0; pos < psalu_pkg::DataW; pos += w) begin
      acc |= lane_calc(kind, (d >> pos) & m, (s >> pos) & m, w) << pos;
    end
    return acc;
  endfunction

  // Each 32-bit half takes the sum of its two signed word products
  function automatic psalu_pkg::data_t pair_madd(psalu_pkg::data_t d, psalu_pkg::data_t s);
    psalu_pkg::data_t acc;
    longint           sum;
    int unsigned      p;
    acc = '0;
    for (p = 0; p < psalu_pkg::DataW; p += psalu_pkg::DwordW) begin
      sum = lane_signed(psalu_pkg::data_t'(d[p +: psalu_pkg::WordW]), psalu_pkg::WordW)
          * lane_signed(psalu_pkg::data_t'(s[p +: psalu_pkg::WordW]), psalu_pkg::WordW)
          + lane_signed(psalu_pkg::data_t'(d[p + psalu_pkg::WordW +: psalu_pkg::WordW]),
                        psalu_pkg::WordW)
          * lane_signed(psalu_pkg::data_t'(s[p + psalu_pkg::WordW +: psalu_pkg::WordW]),
                        psalu_pkg::WordW);
      acc[p +: psalu_pkg::DwordW] = sum[psalu_pkg::DwordW-1:0];
    end
    return acc;
  endfunction

  function automatic psalu_pkg::data_t predict_result(opcode_t op, psalu_pkg::data_t d,
                                                      psalu_pkg::data_t s);
    case (op)
      psalu_pkg::OP_ADD_B:   return lanewise(psalu_pkg::KIND_WRAP_ADD, d, s, psalu_pkg::ByteW);
      psalu_pkg::OP_ADD_W:   return lanewise(psalu_pkg::KIND_WRAP_ADD, d, s, psalu_pkg::WordW);
      psalu_pkg::OP_ADD_D:   return lanewise(psalu_pkg::KIND_WRAP_ADD, d, s, psalu_pkg::DwordW);
      psalu_pkg::OP_SUB_B:   return lanewise(psalu_pkg::KIND_WRAP_SUB, d, s, psalu_pkg::ByteW);
      psalu_pkg::OP_SUB_W:   return lanewise(psalu_pkg::KIND_WRAP_SUB, d, s, psalu_pkg::WordW);
      psalu_pkg::OP_SUB_D:   return lanewise(psalu_pkg::KIND_WRAP_SUB, d, s, psalu_pkg::DwordW);
      psalu_pkg::OP_ADDS_B:  return lanewise(psalu_pkg::KIND_SSAT_ADD, d, s, psalu_pkg::ByteW);
      psalu_pkg::OP_ADDS_W:  return lanewise(psalu_pkg::KIND_SSAT_ADD, d, s, psalu_pkg::WordW);
      psalu_pkg::OP_ADDUS_B: return lanewise(psalu_pkg::KIND_USAT_ADD, d, s, psalu_pkg::ByteW);
      psalu_pkg::OP_ADDUS_W: return lanewise(psalu_pkg::KIND_USAT_ADD, d, s, psalu_pkg::WordW);
      psalu_pkg::OP_SUBS_B:  return lanewise(psalu_pkg::KIND_SSAT_SUB, d, s, psalu_pkg::ByteW);
      psalu_pkg::OP_SUBS_W:  return lanewise(psalu_pkg::KIND_SSAT_SUB, d, s, psalu_pkg::WordW);
      psalu_pkg::OP_SUBUS_B: return lanewise(psalu_pkg::KIND_USAT_SUB, d, s, psalu_pkg::ByteW);
      psalu_pkg::OP_SUBUS_W: return lanewise(psalu_pkg::KIND_USAT_SUB, d, s, psalu_pkg::WordW);
      psalu_pkg::OP_MUL_LO:  return lanewise(psalu_pkg::KIND_MUL_LO, d, s, psalu_pkg::WordW);
      psalu_pkg::OP_MUL_HI:  return lanewise(psalu_pkg::KIND_MUL_HI, d, s, psalu_pkg::WordW);
      psalu_pkg::OP_MADD:    return pair_madd(d, s);
      default:               return d;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: queue of predicted results in acceptance order
  // --------------------------------------------------------------------------
  class result_scoreboard;
    psalu_pkg::data_t expected_q[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_beat(opcode_t op, psalu_pkg::data_t d, psalu_pkg::data_t s);
      expected_q.push_back(predict_result(op, d, s));
    endfunction

    function void check_result(psalu_pkg::data_t got);
      psalu_pkg::data_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected result beat: actual %h", got);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("result mismatch: expected %h, actual %h", want, got);
        end
      end
    endfunction
  endclass

  result_scoreboard sb;
  int unsigned      src_idle_pct;
  int unsigned      sink_idle_pct;
  int unsigned      idle_cycles;

  initial sb = new();

  // Clock
  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Randomly throttle the result channel
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Record accepted beats on both channels and guard against a hang
  always @(posedge clk_i) begin
    if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      sb.note_beat(in_ch.opcode, in_ch.dst_operand, in_ch.src_operand);
    end
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_result(out_ch.result);
    end
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Operands: fully random, or lanes biased towards the saturation corners
  function automatic psalu_pkg::data_t random_operand();
    psalu_pkg::data_t v;
    int               i;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      1: begin
        for (i = 0; i < psalu_pkg::ByteLanes; i++) begin
          case ($urandom_range(5))
            0:       v[i*psalu_pkg::ByteW +: psalu_pkg::ByteW] = 8'h00;
            1:       v[i*psalu_pkg::ByteW +: psalu_pkg::ByteW] = 8'h7F;
            2:       v[i*psalu_pkg::ByteW +: psalu_pkg::ByteW] = 8'h80;
            3:       v[i*psalu_pkg::ByteW +: psalu_pkg::ByteW] = 8'hFF;
            4:       v[i*psalu_pkg::ByteW +: psalu_pkg::ByteW] = 8'h01;
            default: ;
          endcase
        end
      end
      2: begin
        for (i = 0; i < psalu_pkg::WordLanes; i++) begin
          case ($urandom_range(5))
            0:       v[i*psalu_pkg::WordW +: psalu_pkg::WordW] = 16'h0000;
            1:       v[i*psalu_pkg::WordW +: psalu_pkg::WordW] = 16'h7FFF;
            2:       v[i*psalu_pkg::WordW +: psalu_pkg::WordW] = 16'h8000;
            3:       v[i*psalu_pkg::WordW +: psalu_pkg::WordW] = 16'hFFFF;
            4:       v[i*psalu_pkg::WordW +: psalu_pkg::WordW] = 16'h0001;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // Mostly defined operations, now and then an undefined one
  function automatic opcode_t random_opcode();
    if ($urandom_range(99) < 8) return opcode_t'($urandom_range(OpUndefHi, OpUndefLo));
    return opcode_t'($urandom_range(psalu_pkg::OP_MADD));
  endfunction

  // Present one beat after a random gap; return at the falling edge after
  // acceptance with valid still high
  task automatic send_op(input opcode_t op, input psalu_pkg::data_t d,
                         input psalu_pkg::data_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.opcode      = op;
    in_ch.dst_operand = d;
    in_ch.src_operand = s;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  // Hold off the input until every predicted result has come back
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_directed();
    psalu_pkg::data_t mix_d;
    psalu_pkg::data_t mix_s;
    int               op;
    mix_d = 64'h7FFF_8000_FF80_017F;
    mix_s = 64'h7FFF_8000_0180_FF01;
    // Every defined operation on a spread of lane corners
    for (op = psalu_pkg::OP_ADD_B; op <= psalu_pkg::OP_MADD; op++) begin
      send_op(opcode_t'(op), mix_d, mix_s);
    end
    send_op(psalu_pkg::OP_ADD_B, '0, '0);
    send_op(psalu_pkg::OP_ADDUS_W, '1, '1);
    send_op(psalu_pkg::OP_SUBUS_B, '0, '1);
    send_op(psalu_pkg::OP_ADDS_B, 64'h7F7F_7F7F_8080_8080, 64'h0101_0101_FFFF_FFFF);
    send_op(psalu_pkg::OP_SUBS_W, 64'h8000_8000_7FFF_7FFF, 64'h0001_7FFF_FFFF_8000);
    // Multiply-add with every word at the negative extreme wraps each half
    send_op(psalu_pkg::OP_MADD, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
    send_op(psalu_pkg::OP_MUL_HI, 64'h8000_8000_7FFF_7FFF, 64'h8000_7FFF_8000_7FFF);
    // Undefined opcodes pass the destination operand through
    send_op(OpUndefLo, 64'hDEAD_BEEF_0123_4567, '1);
    send_op(OpUndefHi, '1, '0);
  endtask

  task automatic run_random(input int unsigned beats);
    int unsigned i;
    for (i = 0; i < beats; i++) begin
      if (i == beats / 2) drain_results();
      send_op(random_opcode(), random_operand(), random_operand());
    end
  endtask

  initial begin
    idle_cycles       = 0;
    src_idle_pct      = 19;
    sink_idle_pct     = 46;
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = '0;
    in_ch.dst_operand = '0;
    in_ch.src_operand = '0;
    out_ch.ready      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    drain_results();
    run_random(PhaseBeats);

    src_idle_pct  = 46;
    sink_idle_pct = 19;
    run_random(PhaseBeats);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(PhaseBeats);

    // Let the pipeline settle and catch any stray beat
    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/psalu_pkg.sv
hw/rtl/psalu_if.sv
hw/rtl/psalu_decode.sv
hw/rtl/psalu_lane.sv
hw/rtl/psalu_combine.sv
hw/rtl/packed_simd_integer_alu.sv
hw/rtl/psalu_chk.sv
bench/tb_packed_simd_integer_alu.sv
